[rtl/mmsa_pkg.sv]
// Shared constants and types of the modular multiply shift-add core.
package mmsa_pkg;

  localparam int unsigned FieldWidth   = 63;
  localparam int unsigned OperandWidth = 63;

  typedef enum logic [1:0] {
    StIdle,
    StReduce,
    StMultiply
  } state_e;

endpackage

[rtl/mmsa_if.sv]
// Request and result channel interfaces of the modular multiply shift-add core.
interface mmsa_req_if;
  logic                             valid;
  logic                             ready;
  logic [mmsa_pkg::FieldWidth-1:0] multiplicand;
  logic [mmsa_pkg::FieldWidth-1:0] multiplier;
  logic [mmsa_pkg::FieldWidth-1:0] modulus;

  modport source (output valid, output multiplicand, output multiplier, output modulus,
                  input ready);
  modport sink (input valid, input multiplicand, input multiplier, input modulus,
                output ready);
endinterface

interface mmsa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [mmsa_pkg::FieldWidth-1:0] product_mod;

  modport source (output valid, output product_mod, input ready);
  modport sink (input valid, input product_mod, output ready);
endinterface

[rtl/mmsa_add_mod.sv]
// Modular adder: returns (x + y + carry) reduced once by the modulus.
module mmsa_add_mod #(
  parameter int unsigned Width = mmsa_pkg::OperandWidth
) (
  input  logic [Width-1:0] x_i,
  input  logic [Width-1:0] y_i,
  input  logic             cin_i,
  input  logic [Width-1:0] mod_i,
  output logic [Width-1:0] sum_o
);

  logic [Width:0] sum;
  logic [Width:0] diff;

  always_comb begin
    sum  = {1'b0, x_i} + {1'b0, y_i} + {{Width{1'b0}}, cin_i};
    diff = sum - {1'b0, mod_i};
    if (sum >= {1'b0, mod_i}) begin
      sum_o = diff[Width-1:0];
    end else begin
      sum_o = sum[Width-1:0];
    end
  end

endmodule

[rtl/modular_multiply_shift_add_core.sv]
// Interleaved modular multiplier: product_mod = (multiplicand * multiplier) mod modulus.
// The multiplier is first reduced bit-serially by a doubling modular adder; the multiplicand
// is then scanned bit-serially, with a second modular adder accumulating the product.
// Only one request is in flight; the final step waits for the output register to be free.
// A new request is accepted while the previous result waits in the output register.
// Reset (asynchronous, active low) clears the sequencer and the result valid flag.
module modular_multiply_shift_add_core #(
  parameter int unsigned OPERAND_WIDTH = mmsa_pkg::OperandWidth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mmsa_req_if.sink       req_i,
  mmsa_rsp_if.source     rsp_o
);

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned CntW = $clog2(OPERAND_WIDTH);
  localparam int unsigned PadW = mmsa_pkg::FieldWidth - OPERAND_WIDTH;

  mmsa_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [W-1:0]     a_q, a_d;
  logic [W-1:0]     b_q, b_d;
  logic [W-1:0]     m_q, m_d;
  logic [W-1:0]     mult_q, mult_d;
  logic [W-1:0]     acc_q, acc_d;
  logic             zero_mod_q, zero_mod_d;
  logic [W-1:0]     prod_q, prod_d;
  logic             out_valid_q, out_valid_d;
  logic [W-1:0]     dbl_sum;
  logic [W-1:0]     acc_sum;
  logic             dbl_cin;
  logic             last;
  logic             out_free;

  mmsa_add_mod #(.Width(W)) u_dbl (
    .x_i  (mult_q),
    .y_i  (mult_q),
    .cin_i(dbl_cin),
    .mod_i(m_q),
    .sum_o(dbl_sum)
  );

  mmsa_add_mod #(.Width(W)) u_acc (
    .x_i  (acc_q),
    .y_i  (mult_q),
    .cin_i(1'b0),
    .mod_i(m_q),
    .sum_o(acc_sum)
  );

  assign last     = (cnt_q == CntW'(OPERAND_WIDTH - 1));
  assign out_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmsa_pkg::StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    m_q        <= m_d;
    mult_q     <= mult_d;
    acc_q      <= acc_d;
    zero_mod_q <= zero_mod_d;
    prod_q     <= prod_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    a_d         = a_q;
    b_d         = b_q;
    m_d         = m_q;
    mult_d      = mult_q;
    acc_d       = acc_q;
    zero_mod_d  = zero_mod_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q;
    dbl_cin     = 1'b0;
    req_i.ready = 1'b0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      mmsa_pkg::StIdle: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          a_d        = req_i.multiplicand[W-1:0];
          b_d        = req_i.multiplier[W-1:0];
          m_d        = req_i.modulus[W-1:0];
          zero_mod_d = (req_i.modulus[W-1:0] == '0);
          mult_d     = '0;
          acc_d      = '0;
          cnt_d      = '0;
          state_d    = mmsa_pkg::StReduce;
        end
      end
      mmsa_pkg::StReduce: begin
        // Restoring reduction of the multiplier, most significant bit first.
        dbl_cin = b_q[W-1];
        mult_d  = dbl_sum;
        b_d     = {b_q[W-2:0], 1'b0};
        if (last) begin
          cnt_d   = '0;
          state_d = mmsa_pkg::StMultiply;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      mmsa_pkg::StMultiply: begin
        if (!last || out_free) begin
          if (a_q[0]) begin
            acc_d = acc_sum;
          end
          mult_d = dbl_sum;
          a_d    = {1'b0, a_q[W-1:1]};
          if (last) begin
            prod_d      = zero_mod_q ? '0 : acc_d;
            out_valid_d = 1'b1;
            cnt_d       = '0;
            state_d     = mmsa_pkg::StIdle;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = mmsa_pkg::StIdle;
      end
    endcase
  end

  if (PadW > 0) begin : g_pad
    assign rsp_o.product_mod = {{PadW{1'b0}}, prod_q};
  end else begin : g_nopad
    assign rsp_o.product_mod = prod_q;
  end

  assign rsp_o.valid = out_valid_q;

endmodule

[tb/testbench.sv]
// Self-checking testbench of the modular multiply shift-add core.
module testbench;

  localparam int unsigned FieldWidth   = mmsa_pkg::FieldWidth;
  localparam int unsigned OperandWidth = mmsa_pkg::OperandWidth;
  localparam int unsigned NumRandom = 1230;
  localparam int unsigned PhaseLen  = 320;
  localparam int unsigned HoldLen   = 600;
  localparam logic [FieldWidth-1:0] AllOnes     = {FieldWidth{1'b1}};
  localparam logic [FieldWidth-1:0] OperandMask = AllOnes >> (FieldWidth - OperandWidth);

  typedef struct packed {
    logic [FieldWidth-1:0] multiplicand;
    logic [FieldWidth-1:0] multiplier;
    logic [FieldWidth-1:0] modulus;
  } mul_req_t;

  typedef struct packed {
    mul_req_t              req;
    logic [FieldWidth-1:0] product;
  } product_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  mmsa_req_if req_if ();
  mmsa_rsp_if rsp_if ();

  modular_multiply_shift_add_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  mul_req_t    pending_reqs[$];
  product_t    pending_products[$];
  mul_req_t    next_req;
  product_t    exp_product;
  product_t    got_product;
  int unsigned accepted_cnt;
  int unsigned error_cnt = 0;
  int unsigned holdoff_left;
  logic        holdoff_done;

  always #5 clk_i = ~clk_i;

  // Shift-and-add product, every partial value kept below the modulus.
  function automatic logic [FieldWidth-1:0] mod_product(logic [FieldWidth-1:0] a,
                                                        logic [FieldWidth-1:0] b,
                                                        logic [FieldWidth-1:0] m);
    logic [FieldWidth:0] acc;
    logic [FieldWidth:0] mult;
    a = a & OperandMask;
    b = b & OperandMask;
    m = m & OperandMask;
    if (m == '0) begin
      return '0;
    end
    acc  = '0;
    mult = {1'b0, b % m};
    for (int i = 0; i < OperandWidth; i++) begin
      if (a[i]) begin
        acc = acc + mult;
        if (acc >= {1'b0, m}) begin
          acc = acc - {1'b0, m};
        end
      end
      mult = mult << 1;
      if (mult >= {1'b0, m}) begin
        mult = mult - {1'b0, m};
      end
    end
    return acc[FieldWidth-1:0];
  endfunction

  function automatic int unsigned send_idle_pct(int unsigned cnt);
    case ((cnt / PhaseLen) % 4)
      1: return 59;
      3: return 17;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned stall_pct(int unsigned cnt);
    case ((cnt / PhaseLen) % 4)
      2: return 59;
      3: return 17;
      default: return 0;
    endcase
  endfunction

  function automatic logic [FieldWidth-1:0] pick_operand(bit nonzero);
    logic [63:0]           raw;
    logic [FieldWidth-1:0] v;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = AllOnes;
      2: v = FieldWidth'($urandom_range(1, 255));
      3: v = FieldWidth'(1) << $urandom_range(0, FieldWidth - 1);
      4: v = AllOnes >> $urandom_range(0, FieldWidth - 1);
      5: v = raw[FieldWidth-1:0] >> $urandom_range(0, FieldWidth - 1);
      default: v = raw[FieldWidth-1:0];
    endcase
    if (nonzero && v == '0) begin
      v = FieldWidth'(1);
    end
    return v;
  endfunction

  task automatic add_req(logic [FieldWidth-1:0] a, logic [FieldWidth-1:0] b,
                         logic [FieldWidth-1:0] m);
    mul_req_t r;
    r.multiplicand = a;
    r.multiplier   = b;
    r.modulus      = m;
    pending_reqs.push_back(r);
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.multiplicand <= '0;
      req_if.multiplier   <= '0;
      req_if.modulus      <= '0;
      accepted_cnt        <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        exp_product.req.multiplicand = req_if.multiplicand;
        exp_product.req.multiplier   = req_if.multiplier;
        exp_product.req.modulus      = req_if.modulus;
        exp_product.product = mod_product(req_if.multiplicand, req_if.multiplier,
                                          req_if.modulus);
        pending_products.push_back(exp_product);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct(accepted_cnt)) begin
          next_req = pending_reqs.pop_front();
          req_if.valid        <= 1'b1;
          req_if.multiplicand <= next_req.multiplicand;
          req_if.multiplier   <= next_req.multiplier;
          req_if.modulus      <= next_req.modulus;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // The result side holds off once for a long stretch so that the core backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (!holdoff_done && accepted_cnt >= 40) begin
      holdoff_left <= HoldLen;
      holdoff_done <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Result monitor and checker.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_products.size() == 0) begin
          $display("%0t: unexpected result: product_mod %h", $time, rsp_if.product_mod);
          error_cnt++;
        end else begin
          got_product = pending_products.pop_front();
          if (rsp_if.product_mod !== got_product.product) begin
            $display("%0t: product_mod mismatch (a %h b %h m %h): expected %h, actual %h",
                     $time, got_product.req.multiplicand, got_product.req.multiplier,
                     got_product.req.modulus, got_product.product, rsp_if.product_mod);
            error_cnt++;
          end
        end
      end
      rsp_if.ready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= stall_pct(accepted_cnt));
    end
  end

  initial begin
    logic [FieldWidth-1:0] a;
    logic [FieldWidth-1:0] b;
    logic [FieldWidth-1:0] m;
    rst_ni <= 1'b0;

    add_req('0, '0, FieldWidth'(1));
    add_req(AllOnes, AllOnes, FieldWidth'(1));
    add_req('0, AllOnes, AllOnes);
    add_req(AllOnes, '0, AllOnes);
    add_req(AllOnes, AllOnes, AllOnes);
    add_req(AllOnes, AllOnes, AllOnes - 1);
    add_req(AllOnes, FieldWidth'(1), AllOnes);
    add_req(FieldWidth'(1), AllOnes, AllOnes - 1);
    add_req(AllOnes, AllOnes, FieldWidth'(2));
    add_req(FieldWidth'(5), FieldWidth'(7), FieldWidth'(2));
    add_req(FieldWidth'(5), FieldWidth'(7), FieldWidth'(3));
    add_req(FieldWidth'(12345), FieldWidth'(678), FieldWidth'(1000));
    add_req(FieldWidth'(1), FieldWidth'(1), FieldWidth'(1) << (FieldWidth - 1));
    add_req(FieldWidth'(1) << (FieldWidth - 1), FieldWidth'(1) << (FieldWidth - 1), AllOnes);
    add_req(AllOnes, AllOnes, (FieldWidth'(1) << (FieldWidth - 1)) + 1);
    add_req(AllOnes, AllOnes, FieldWidth'(1) << (FieldWidth - 1));
    add_req(FieldWidth'(1), AllOnes, FieldWidth'(3));
    add_req(FieldWidth'(1), FieldWidth'(10), FieldWidth'(7));
    add_req(FieldWidth'(3), FieldWidth'(1) << (FieldWidth - 1),
            (FieldWidth'(1) << (FieldWidth - 1)) - 1);
    add_req(FieldWidth'({(FieldWidth+1)/2{2'b01}}), FieldWidth'({(FieldWidth+1)/2{2'b10}}),
            AllOnes);
    add_req(FieldWidth'({(FieldWidth+1)/2{2'b10}}), FieldWidth'({(FieldWidth+1)/2{2'b01}}),
            AllOnes - 2);

    for (int n = 0; n < NumRandom; n++) begin
      a = pick_operand(1'b0);
      b = pick_operand(1'b0);
      m = pick_operand(1'b1);
      case ($urandom_range(0, 7))
        0: b = m - 1;
        1: b = m;
        2: b = m + FieldWidth'($urandom_range(1, 3));
        default: ;
      endcase
      add_req(a, b, m);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || req_if.valid) begin
      @(posedge clk_i);
    end
    while (pending_products.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2 * OperandWidth + 8) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
